// ===== hdl/ppsc_pkg.sv =====
package ppsc_pkg;

    // angle units: 1/64 degree
    localparam int TURN         = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;
    localparam int THIRD_TURN   = 7680;
    localparam int SIX_VOLTS    = 24576;

    // quarter-wave cosine table
    localparam int COS_DEPTH = 256;
    localparam int DB        = $clog2(COS_DEPTH);
    localparam int FULL      = 4 * COS_DEPTH;
    localparam int FB        = $clog2(FULL);

    // TURN is 45 << 9; floor(v / 45) = (v * RECIP_45) >> RECIP_SHIFT holds
    // exactly for v below 74898
    localparam int TURN_SHIFT  = 9;
    localparam int TURN_COARSE = 45;
    localparam int RECIP_45    = 23302;
    localparam int RECIP_SHIFT = 20;
    // bias makes the electrical angle positive and is a whole number of turns
    localparam int MOD_BIAS    = TURN * 512;
    // round(p * FULL / TURN) = floor((2p + 22) / 45) for this table depth
    localparam int IDX_OFFSET  = 22;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [15:0] cos_rom_t [COS_DEPTH];

    typedef enum logic [2:0] {
        REG_ZERO_OFFSET     = 3'd0,
        REG_PAIR_COUNT      = 3'd1,
        REG_GAIN_P          = 3'd2,
        REG_GAIN_D          = 3'd3,
        REG_GAIN_I          = 3'd4,
        REG_INTEGRAL_LIMIT  = 3'd5,
        REG_VOLTAGE_LIMIT   = 3'd6,
        REG_COUNTS_PER_VOLT = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_ELEC,
        MUL_GP,
        MUL_GD,
        MUL_GI,
        MUL_COS,
        MUL_DUTY
    } mul_sel_t;

    typedef struct packed {
        logic            load_in;
        logic            integ;
        logic            mul_en;
        mul_sel_t        mul_sel;
        logic            elec_ld;
        logic            sum_ld;
        logic            sum_acc;
        logic            prev_ld;
        logic            vq_ld;
        logic            ang_ld;
        logic            turn_ld;
        logic            pa_ld;
        logic            idx_ld;
        logic            cos_ld;
        logic            vinv_ld;
        logic            duty_ld;
        logic [1:0]      phase;
        logic            out_ld;
    } ppsc_cmd_t;

    // Taylor series in Q30, nine Horner terms, evaluated at elaboration
    function automatic cos_rom_t cos_rom_build();
        cos_rom_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] r;
        for (int k = 0; k < COS_DEPTH; k++)
        begin
            x  = (HALF_PI_Q30 * 64'(k)) / COS_DEPTH;
            x2 = (x * x) >> 30;
            c  = Q30_ONE;
            t = ((x2 * c) >> 30) / 64'd306;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd240;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd182;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd132;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd90;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd56;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd30;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd12;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            t = ((x2 * c) >> 30) / 64'd2;
            c = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
            r = (c + 64'd8192) >> 14;
            rom[k] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = cos_rom_build();

endpackage

// ===== hdl/ppsc_ctrl.sv =====
module ppsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ppsc_pkg::ppsc_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELEC,
        S_MP,
        S_MD,
        S_MI,
        S_SUM,
        S_LIM,
        S_RED,
        S_RMD,
        S_IDX,
        S_LOOK,
        S_CM,
        S_VINV,
        S_DM,
        S_SAT,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [1:0]                phase_reg;
    logic                      out_valid_reg;
    logic                      out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_ELEC;
                end
                S_ELEC: state_reg <= S_MP;
                S_MP:   state_reg <= S_MD;
                S_MD:   state_reg <= S_MI;
                S_MI:   state_reg <= S_SUM;
                S_SUM:  state_reg <= S_LIM;
                S_LIM:  state_reg <= S_RED;
                S_RED:  state_reg <= S_RMD;
                S_RMD:
                begin
                    phase_reg <= '0;
                    state_reg <= S_IDX;
                end
                S_IDX:  state_reg <= S_LOOK;
                S_LOOK: state_reg <= S_CM;
                S_CM:   state_reg <= S_VINV;
                S_VINV: state_reg <= S_DM;
                S_DM:   state_reg <= S_SAT;
                S_SAT:
                begin
                    if (phase_reg == 2'd2)
                        state_reg <= S_DONE;
                    else
                    begin
                        phase_reg <= phase_reg + 1'b1;
                        state_reg <= S_IDX;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = ppsc_pkg::MUL_ELEC;
        cmd.phase   = phase_reg;
        unique case (state_reg)
            S_IDLE: cmd.load_in = in_valid;
            S_ELEC:
            begin
                cmd.integ   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppsc_pkg::MUL_ELEC;
            end
            S_MP:
            begin
                cmd.elec_ld = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppsc_pkg::MUL_GP;
            end
            S_MD:
            begin
                cmd.sum_ld  = 1'b1;
                cmd.ang_ld  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppsc_pkg::MUL_GD;
            end
            S_MI:
            begin
                cmd.sum_acc = 1'b1;
                cmd.prev_ld = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppsc_pkg::MUL_GI;
            end
            S_SUM:  cmd.sum_acc = 1'b1;
            S_LIM:  cmd.vq_ld   = 1'b1;
            S_RED:  cmd.turn_ld = 1'b1;
            S_RMD:  cmd.pa_ld   = 1'b1;
            S_IDX:  cmd.idx_ld  = 1'b1;
            S_LOOK: cmd.cos_ld  = 1'b1;
            S_CM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppsc_pkg::MUL_COS;
            end
            S_VINV: cmd.vinv_ld = 1'b1;
            S_DM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppsc_pkg::MUL_DUTY;
            end
            S_SAT:  cmd.duty_ld = 1'b1;
            S_DONE: cmd.out_ld  = out_free;
            default: cmd.load_in = 1'b0;
        endcase
    end

endmodule

// ===== hdl/ppsc_dp.sv =====
module ppsc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  ppsc_pkg::ppsc_cmd_t cmd,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [23:0]         cfg_wdata,
    input  logic [15:0]         in_rotor_angle,
    input  logic [16:0]         in_position_error,
    output logic [15:0]         duty_a,
    output logic [15:0]         duty_b,
    output logic [15:0]         duty_c,
    output logic [15:0]         drive_voltage,
    output logic [14:0]         wrapped_error,
    output logic                integral_clamped
);

    localparam int FB = ppsc_pkg::FB;
    localparam int DB = ppsc_pkg::DB;

    // configuration
    logic signed [15:0] zero_offset_reg;
    logic [6:0]         pair_count_reg;
    logic signed [23:0] gain_p_reg;
    logic signed [23:0] gain_d_reg;
    logic signed [23:0] gain_i_reg;
    logic [19:0]        ilimit_reg;
    logic [14:0]        vlimit_reg;
    logic [23:0]        cpv_reg;

    // loop state
    logic signed [20:0] integ_reg;
    logic signed [14:0] prev_reg;

    // working registers
    logic signed [15:0] rot_reg;
    logic signed [14:0] err_reg;
    logic               clamp_reg;
    logic signed [24:0] elec_reg;
    logic signed [46:0] prod_reg;
    logic signed [47:0] sum_reg;
    logic signed [15:0] vq_reg;
    logic [24:0]        ang_reg;
    logic [9:0]         turn_reg;
    logic [14:0]        pa_reg;
    logic [FB-1:0]      idx_reg;
    logic signed [16:0] cos_reg;
    logic [16:0]        vinv_reg;
    logic [15:0]        duty_reg [3];

    // result register
    logic [15:0]        out_duty_reg [3];
    logic [15:0]        out_vq_reg;
    logic [14:0]        out_err_reg;
    logic               out_clamp_reg;

    // error wrap
    logic signed [17:0] ew0;
    logic signed [17:0] ew1;
    logic signed [14:0] err_wrapped;

    always_comb
    begin
        ew0 = {in_position_error[16], in_position_error};
        if (ew0 > 18'sd11520)
            ew1 = ew0 - 18'sd23040;
        else if (ew0 < -18'sd11520)
            ew1 = ew0 + 18'sd23040;
        else
            ew1 = ew0;
        if (ew1 > 18'sd11520)
            err_wrapped = 15'sd11520;
        else if (ew1 < -18'sd11520)
            err_wrapped = -15'sd11520;
        else
            err_wrapped = ew1[14:0];
    end

    // integral clamp
    logic signed [21:0] iacc;
    logic signed [21:0] ilim;

    assign iacc = {integ_reg[20], integ_reg} + {{7{err_reg[14]}}, err_reg};
    assign ilim = {2'b00, ilimit_reg};

    // shared multiplier
    logic signed [16:0] rot_rel;
    logic signed [15:0] err_diff;
    logic signed [24:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [46:0] mul_p;

    assign rot_rel  = {rot_reg[15], rot_reg} - {zero_offset_reg[15], zero_offset_reg};
    assign err_diff = {err_reg[14], err_reg} - {prev_reg[14], prev_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            ppsc_pkg::MUL_ELEC:
            begin
                mul_a = {18'd0, pair_count_reg};
                mul_b = {{5{rot_rel[16]}}, rot_rel};
            end
            ppsc_pkg::MUL_GP:
            begin
                mul_a = {gain_p_reg[23], gain_p_reg};
                mul_b = {{7{err_reg[14]}}, err_reg};
            end
            ppsc_pkg::MUL_GD:
            begin
                mul_a = {gain_d_reg[23], gain_d_reg};
                mul_b = {{6{err_diff[15]}}, err_diff};
            end
            ppsc_pkg::MUL_GI:
            begin
                mul_a = {gain_i_reg[23], gain_i_reg};
                mul_b = {integ_reg[20], integ_reg};
            end
            ppsc_pkg::MUL_COS:
            begin
                mul_a = {{8{cos_reg[16]}}, cos_reg};
                mul_b = {{6{vq_reg[15]}}, vq_reg};
            end
            default:
            begin
                mul_a = {1'b0, cpv_reg};
                mul_b = {5'd0, vinv_reg};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // voltage clamp, floor of sum / 1024
    logic signed [47:0] vq_raw;
    logic signed [47:0] vlim;
    logic signed [15:0] vq_next;

    assign vq_raw = sum_reg >>> 10;
    assign vlim   = {33'd0, vlimit_reg};

    always_comb
    begin
        if (vq_raw > vlim)
            vq_next = {1'b0, vlimit_reg};
        else if (vq_raw < -vlim)
            vq_next = -$signed({1'b0, vlimit_reg});
        else
            vq_next = vq_raw[15:0];
    end

    // angle modulo TURN: coarse part (bits 9 and up) modulo 45 by reciprocal
    logic [15:0] ang_hi;
    logic [30:0] turn_prod;
    logic [15:0] turn_sub;

    assign ang_hi    = ang_reg[24:ppsc_pkg::TURN_SHIFT];
    assign turn_prod = {15'd0, ang_hi} * 31'(ppsc_pkg::RECIP_45);
    assign turn_sub  = ang_hi - ({6'd0, turn_reg} * 16'(ppsc_pkg::TURN_COARSE));

    // per-phase angles after reduction of phase A
    logic [14:0] pa;
    logic [14:0] pb;
    logic [14:0] pc;

    assign pa = pa_reg;
    assign pb = (pa < 15'(ppsc_pkg::THIRD_TURN))
        ? pa + 15'(ppsc_pkg::TURN - ppsc_pkg::THIRD_TURN)
        : pa - 15'(ppsc_pkg::THIRD_TURN);
    assign pc = (pa >= 15'(ppsc_pkg::TURN - ppsc_pkg::THIRD_TURN))
        ? pa - 15'(ppsc_pkg::TURN - ppsc_pkg::THIRD_TURN)
        : pa + 15'(ppsc_pkg::THIRD_TURN);

    // rounded table index; the quotient can reach FULL and wraps to zero
    logic [14:0] psel;
    logic [15:0] idx_num;
    logic [30:0] idx_prod;

    always_comb
    begin
        case (cmd.phase)
            2'd0:    psel = pa;
            2'd1:    psel = pb;
            default: psel = pc;
        endcase
    end

    assign idx_num  = {psel, 1'b0} + 16'(ppsc_pkg::IDX_OFFSET);
    assign idx_prod = {15'd0, idx_num} * 31'(ppsc_pkg::RECIP_45);

    // table lookup with quadrant reflection
    logic [FB-1:0]      idx;
    logic [DB-1:0]      ridx;
    logic [DB-1:0]      rref;
    logic [15:0]        tdir;
    logic [15:0]        tref;
    logic signed [16:0] cos_next;

    assign idx  = idx_reg;
    assign ridx = idx[DB-1:0];
    assign rref = -ridx;
    assign tdir = ppsc_pkg::COS_ROM[ridx];
    assign tref = (ridx == '0) ? 16'd0 : ppsc_pkg::COS_ROM[rref];

    always_comb
    begin
        case (idx[FB-1:FB-2])
            2'd0:    cos_next = $signed({1'b0, tdir});
            2'd1:    cos_next = -$signed({1'b0, tref});
            2'd2:    cos_next = -$signed({1'b0, tdir});
            default: cos_next = $signed({1'b0, tref});
        endcase
    end

    // inverter voltage and duty saturation
    logic signed [17:0] vinv_full;
    logic [15:0]        duty_next;

    assign vinv_full = {prod_reg[32], prod_reg[32:16]} + 18'(ppsc_pkg::SIX_VOLTS);
    assign duty_next = (|prod_reg[46:36]) ? 16'hFFFF : prod_reg[35:20];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= -16'sd11475;
            pair_count_reg  <= 7'd11;
            gain_p_reg      <= '0;
            gain_d_reg      <= '0;
            gain_i_reg      <= '0;
            ilimit_reg      <= 20'd384000;
            vlimit_reg      <= 15'd12288;
            cpv_reg         <= 24'd21333;
            integ_reg       <= '0;
            prev_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (ppsc_pkg::reg_idx_t'(cfg_addr))
                    ppsc_pkg::REG_ZERO_OFFSET:     zero_offset_reg <= cfg_wdata[15:0];
                    ppsc_pkg::REG_PAIR_COUNT:      pair_count_reg  <= cfg_wdata[6:0];
                    ppsc_pkg::REG_GAIN_P:          gain_p_reg      <= cfg_wdata;
                    ppsc_pkg::REG_GAIN_D:          gain_d_reg      <= cfg_wdata;
                    ppsc_pkg::REG_GAIN_I:          gain_i_reg      <= cfg_wdata;
                    ppsc_pkg::REG_INTEGRAL_LIMIT:  ilimit_reg      <= cfg_wdata[19:0];
                    ppsc_pkg::REG_VOLTAGE_LIMIT:   vlimit_reg      <= cfg_wdata[14:0];
                    ppsc_pkg::REG_COUNTS_PER_VOLT: cpv_reg         <= cfg_wdata;
                    default:                       cpv_reg         <= cpv_reg;
                endcase
            end
            if (cmd.integ)
            begin
                if (iacc > ilim)
                    integ_reg <= ilim[20:0];
                else if (iacc < -ilim)
                    integ_reg <= -$signed(ilim[20:0]);
                else
                    integ_reg <= iacc[20:0];
            end
            if (cmd.prev_ld)
                prev_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rot_reg <= in_rotor_angle;
            err_reg <= err_wrapped;
        end
        if (cmd.integ)
            clamp_reg <= (iacc > ilim) || (iacc < -ilim);
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.elec_ld)
            elec_reg <= prod_reg[24:0] + 25'(ppsc_pkg::QUARTER_TURN);
        if (cmd.sum_ld)
            sum_reg <= {prod_reg[46], prod_reg};
        else if (cmd.sum_acc)
            sum_reg <= sum_reg + {prod_reg[46], prod_reg};
        if (cmd.vq_ld)
            vq_reg <= vq_next;
        if (cmd.ang_ld)
            ang_reg <= $unsigned(elec_reg) + 25'(ppsc_pkg::MOD_BIAS);
        if (cmd.turn_ld)
            turn_reg <= turn_prod[ppsc_pkg::RECIP_SHIFT +: 10];
        if (cmd.pa_ld)
            pa_reg <= {turn_sub[5:0], ang_reg[ppsc_pkg::TURN_SHIFT-1:0]};
        if (cmd.idx_ld)
            idx_reg <= idx_prod[ppsc_pkg::RECIP_SHIFT +: FB];
        if (cmd.cos_ld)
            cos_reg <= cos_next;
        if (cmd.vinv_ld)
            vinv_reg <= (vinv_full <= 18'sd0) ? 17'd0 : vinv_full[16:0];
        if (cmd.duty_ld)
        begin
            case (cmd.phase)
                2'd0:    duty_reg[0] <= duty_next;
                2'd1:    duty_reg[1] <= duty_next;
                default: duty_reg[2] <= duty_next;
            endcase
        end
        if (cmd.out_ld)
        begin
            out_duty_reg  <= duty_reg;
            out_vq_reg    <= vq_reg;
            out_err_reg   <= err_reg;
            out_clamp_reg <= clamp_reg;
        end
    end

    assign duty_a           = out_duty_reg[0];
    assign duty_b           = out_duty_reg[1];
    assign duty_c           = out_duty_reg[2];
    assign drive_voltage    = out_vq_reg;
    assign wrapped_error    = out_err_reg;
    assign integral_clamped = out_clamp_reg;

endmodule

// ===== hdl/position_pid_sine_commutation.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  rotor angle, position error
// m_axis    out  m_axis_tvalid / m_axis_tready  duties A/B/C, Vq, error, clamp flag
// cfg       in   cfg_we                          cfg_addr, cfg_wdata
//
// A request, once accepted, is worked out on a 25x22 multiplier shared by the
// PID terms, the electrical angle and both duty products, in this order: the
// loop, the angle reduction, then per phase index, table, cosine product,
// inverter voltage, duty product and saturation, and last the write-back.
// The input is ready again the cycle after the result is registered.
// Reset clears configuration to defaults, the integral and the last error.
// A finished result waits in the output register; the next request is
// accepted meanwhile and stalls only at its own write-back.
module position_pid_sine_commutation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] rotor_angle, [32:16] position_error, [39:33] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c, [63:48] drive_voltage,
    // [78:64] wrapped_error, [79] integral_clamped
    output logic [79:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    ppsc_pkg::ppsc_cmd_t cmd;

    ppsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    ppsc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .in_rotor_angle    (s_axis_tdata[15:0]),
        .in_position_error (s_axis_tdata[32:16]),
        .duty_a            (m_axis_tdata[15:0]),
        .duty_b            (m_axis_tdata[31:16]),
        .duty_c            (m_axis_tdata[47:32]),
        .drive_voltage     (m_axis_tdata[63:48]),
        .wrapped_error     (m_axis_tdata[78:64]),
        .integral_clamped  (m_axis_tdata[79])
    );

endmodule
